### rtl/fall_window_classifier_assert.svh
// Assertion macros used by the top-level file that checks this block.
`ifndef FALL_WINDOW_CLASSIFIER_ASSERT_SVH
`define FALL_WINDOW_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fwc_pkg.sv
`timescale 1ns / 1ps

package fwc_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CONF_W = 7;
  localparam int unsigned STATE_W = 3;

  localparam int unsigned TRIPLE_W = 14;
  localparam int unsigned PROD_W = 30;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam logic [COUNT_W-1:0] MIN_TAIL_LEN = 12'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_FREEFALL_LEVEL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMPACT_LEVEL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_LEVEL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STILLNESS_SPREAD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY_SPREAD = 3'd4;

  localparam logic [DATA_W-1:0] FREEFALL_LEVEL_RESET = 16'd1024;
  localparam logic [DATA_W-1:0] IMPACT_LEVEL_RESET = 16'd5120;
  localparam logic [DATA_W-1:0] ROTATION_LEVEL_RESET = 16'd3200;
  localparam logic [DATA_W-1:0] STILLNESS_SPREAD_RESET = 16'd256;
  localparam logic [DATA_W-1:0] RECOVERY_SPREAD_RESET = 16'd768;

  localparam logic [STATE_W-1:0] STATE_NORMAL = 3'd0;
  localparam logic [STATE_W-1:0] STATE_FREE_FALL = 3'd1;
  localparam logic [STATE_W-1:0] STATE_IMPACT = 3'd2;
  localparam logic [STATE_W-1:0] STATE_ROTATION = 3'd3;
  localparam logic [STATE_W-1:0] STATE_VERIFY = 3'd5;
  localparam logic [STATE_W-1:0] STATE_CONFIRMED = 3'd6;
  localparam logic [STATE_W-1:0] STATE_RESOLVED = 3'd7;

  localparam logic [CONF_W-1:0] CONF_NONE = 7'd0;
  localparam logic [CONF_W-1:0] CONF_LOW = 7'd25;
  localparam logic [CONF_W-1:0] CONF_MID = 7'd50;
  localparam logic [CONF_W-1:0] CONF_HIGH = 7'd65;
  localparam logic [CONF_W-1:0] CONF_TOP = 7'd85;
  localparam logic [CONF_W-1:0] FALL_CONF_MIN = 7'd40;

  typedef struct packed {
    logic load;
    logic tail_mul;
    logic tail_set;
    logic scan_step;
    logic emit;
  } fwc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } fwc_status_t;

endpackage

### rtl/fwc_ctrl.sv
`timescale 1ns / 1ps

module fwc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last_sample,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fwc_pkg::fwc_status_t status,
  output fwc_pkg::fwc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    TAIL_MUL,
    TAIL_SET,
    SCAN,
    DRAIN,
    CLASSIFY
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.load = in_valid;
        if (in_valid && last_sample) begin
          state_next = TAIL_MUL;
        end
      end
      TAIL_MUL: begin
        cmd.tail_mul = 1'b1;
        state_next = TAIL_SET;
      end
      TAIL_SET: begin
        cmd.tail_set = 1'b1;
        state_next = SCAN;
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        state_next = CLASSIFY;
      end
      CLASSIFY: begin
        cmd.emit = !out_valid || out_ready;
        if (!out_valid || out_ready) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/fwc_datapath.sv
`timescale 1ns / 1ps

module fwc_datapath #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fwc_pkg::fwc_cmd_t                      cmd,
  output fwc_pkg::fwc_status_t                   status,
  input  logic                                   cfg_write,
  input  logic [fwc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [fwc_pkg::DATA_W-1:0]             cfg_data,
  input  logic [fwc_pkg::DATA_W-1:0]             accel_magnitude,
  input  logic [fwc_pkg::DATA_W-1:0]             gyro_magnitude,
  output logic                                   is_fall,
  output logic [fwc_pkg::STATE_W-1:0]            fall_state,
  output logic                                   free_fall_seen,
  output logic                                   impact_seen,
  output logic                                   rotation_seen,
  output logic                                   stillness_seen,
  output logic                                   recovered,
  output logic [fwc_pkg::CONF_W-1:0]             confidence,
  output logic                                   window_overflow
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned TAIL_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [fwc_pkg::COUNT_W-1:0] DEPTH_COUNT = fwc_pkg::COUNT_W'(RING_DEPTH);

  logic [fwc_pkg::DATA_W-1:0] freefall_level;
  logic [fwc_pkg::DATA_W-1:0] impact_level;
  logic [fwc_pkg::DATA_W-1:0] rotation_level;
  logic [fwc_pkg::DATA_W-1:0] stillness_spread;
  logic [fwc_pkg::DATA_W-1:0] recovery_spread;

  logic [fwc_pkg::DATA_W-1:0] accel_ring [RING_DEPTH];
  logic [fwc_pkg::DATA_W-1:0] ring_q;
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic [fwc_pkg::COUNT_W-1:0] sample_count;
  logic [fwc_pkg::DATA_W-1:0] accel_minimum;
  logic [fwc_pkg::DATA_W-1:0] accel_maximum;
  logic [fwc_pkg::DATA_W-1:0] gyro_maximum;

  logic [fwc_pkg::COUNT_W-2:0] tail_raw;
  logic [TAIL_W-1:0] scan_left;
  logic read_valid;
  logic overflow;
  logic [fwc_pkg::DATA_W-1:0] scan_low;
  logic [fwc_pkg::DATA_W-1:0] scan_high;

  logic [fwc_pkg::TRIPLE_W-1:0] count_triple;
  logic [fwc_pkg::PROD_W-1:0] tail_prod;
  logic [fwc_pkg::COUNT_W-1:0] tail_floor;
  logic [fwc_pkg::COUNT_W-1:0] tail_clamped;
  logic tail_overflow;

  logic [fwc_pkg::DATA_W-1:0] spread;
  logic ff;
  logic imp;
  logic rot;
  logic still;
  logic rec;
  logic [fwc_pkg::STATE_W-1:0] class_code;
  logic [fwc_pkg::CONF_W-1:0] class_conf;

  assign status.scan_last = (scan_left == TAIL_W'(1));

  // Take three tenths of the sample count: divide by ten through a reciprocal multiply, exact for this range.
  assign count_triple = fwc_pkg::TRIPLE_W'({sample_count, 1'b0})
                      + fwc_pkg::TRIPLE_W'(sample_count);
  assign tail_prod = fwc_pkg::PROD_W'(count_triple) * fwc_pkg::PROD_W'(fwc_pkg::RECIP_TEN);

  always_comb begin
    tail_floor = fwc_pkg::COUNT_W'(tail_raw);
    if (tail_floor < fwc_pkg::MIN_TAIL_LEN) begin
      tail_floor = fwc_pkg::MIN_TAIL_LEN;
    end
    tail_clamped = (tail_floor > sample_count) ? sample_count : tail_floor;
    tail_overflow = (tail_clamped > DEPTH_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_level <= fwc_pkg::FREEFALL_LEVEL_RESET;
      impact_level <= fwc_pkg::IMPACT_LEVEL_RESET;
      rotation_level <= fwc_pkg::ROTATION_LEVEL_RESET;
      stillness_spread <= fwc_pkg::STILLNESS_SPREAD_RESET;
      recovery_spread <= fwc_pkg::RECOVERY_SPREAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fwc_pkg::REG_FREEFALL_LEVEL: freefall_level <= cfg_data;
        fwc_pkg::REG_IMPACT_LEVEL: impact_level <= cfg_data;
        fwc_pkg::REG_ROTATION_LEVEL: rotation_level <= cfg_data;
        fwc_pkg::REG_STILLNESS_SPREAD: stillness_spread <= cfg_data;
        fwc_pkg::REG_RECOVERY_SPREAD: recovery_spread <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accel_ring[write_ptr] <= accel_magnitude;
    end
    if (cmd.scan_step) begin
      ring_q <= accel_ring[read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      sample_count <= '0;
      accel_minimum <= '1;
      accel_maximum <= '0;
      gyro_maximum <= '0;
      scan_left <= '0;
      read_valid <= 1'b0;
    end else begin
      read_valid <= cmd.scan_step;
      if (cmd.load) begin
        write_ptr <= (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
        if (sample_count != fwc_pkg::COUNT_MAX) begin
          sample_count <= sample_count + 1'b1;
        end
        if (accel_magnitude < accel_minimum) begin
          accel_minimum <= accel_magnitude;
        end
        if (accel_magnitude > accel_maximum) begin
          accel_maximum <= accel_magnitude;
        end
        if (gyro_magnitude > gyro_maximum) begin
          gyro_maximum <= gyro_magnitude;
        end
      end
      if (cmd.tail_set) begin
        scan_left <= tail_overflow ? TAIL_W'(RING_DEPTH) : TAIL_W'(tail_clamped);
      end else if (cmd.scan_step) begin
        scan_left <= scan_left - 1'b1;
      end
      if (cmd.emit) begin
        write_ptr <= '0;
        sample_count <= '0;
        accel_minimum <= '1;
        accel_maximum <= '0;
        gyro_maximum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tail_mul) begin
      tail_raw <= tail_prod[fwc_pkg::PROD_W-1:fwc_pkg::RECIP_SHIFT];
    end
    if (cmd.tail_set) begin
      overflow <= tail_overflow;
      read_ptr <= (write_ptr == '0) ? PTR_LAST : write_ptr - 1'b1;
      scan_low <= '1;
      scan_high <= '0;
    end else begin
      if (cmd.scan_step) begin
        read_ptr <= (read_ptr == '0) ? PTR_LAST : read_ptr - 1'b1;
      end
      if (read_valid) begin
        if (ring_q < scan_low) begin
          scan_low <= ring_q;
        end
        if (ring_q > scan_high) begin
          scan_high <= ring_q;
        end
      end
    end
  end

  always_comb begin
    spread = scan_high - scan_low;
    ff = (accel_minimum < freefall_level);
    imp = (accel_maximum > impact_level);
    rot = (gyro_maximum > rotation_level);
    still = (spread < stillness_spread);
    rec = (spread > recovery_spread) && imp;
    class_code = fwc_pkg::STATE_NORMAL;
    class_conf = fwc_pkg::CONF_NONE;
    if (rec) begin
      class_code = fwc_pkg::STATE_RESOLVED;
      still = 1'b0;
    end else if (ff && imp && rot && still) begin
      class_code = fwc_pkg::STATE_CONFIRMED;
      class_conf = fwc_pkg::CONF_TOP;
    end else if (ff && imp && rot) begin
      class_code = fwc_pkg::STATE_VERIFY;
      class_conf = fwc_pkg::CONF_HIGH;
    end else if (ff && imp) begin
      class_code = fwc_pkg::STATE_IMPACT;
      class_conf = fwc_pkg::CONF_MID;
    end else if (ff) begin
      class_code = fwc_pkg::STATE_FREE_FALL;
      class_conf = fwc_pkg::CONF_LOW;
    end else if (imp) begin
      class_code = fwc_pkg::STATE_ROTATION;
      class_conf = fwc_pkg::CONF_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      is_fall <= (class_conf >= fwc_pkg::FALL_CONF_MIN);
      fall_state <= class_code;
      free_fall_seen <= ff;
      impact_seen <= imp;
      rotation_seen <= rot;
      stillness_seen <= still;
      recovered <= rec;
      confidence <= class_conf;
      window_overflow <= overflow;
    end
  end

endmodule

### rtl/fall_window_classifier.sv
`timescale 1ns / 1ps

// Fall window classifier. Each word on the input channel is one motion sample
// (acceleration and gyro magnitude); the word flagged by last_sample closes the
// window and produces exactly one classification word on the output channel.
// Ordinary samples are taken back to back while idle. The closing sample scans
// the tail, the recent samples inspected (at most RING_DEPTH), reading one ring
// entry per cycle through the single read port to find the tail spread; input
// is held off meanwhile. A result may wait in the output register while the
// next window loads; that window's result waits until the first is taken. The
// user must write threshold registers through the plain configuration port
// while the block is idle (not enforced); indexes above four are ignored.

module fall_window_classifier #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fwc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fwc_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fwc_pkg::DATA_W-1:0]      accel_magnitude,
  input  logic [fwc_pkg::DATA_W-1:0]      gyro_magnitude,
  input  logic                            last_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            is_fall,
  output logic [fwc_pkg::STATE_W-1:0]     fall_state,
  output logic                            free_fall_seen,
  output logic                            impact_seen,
  output logic                            rotation_seen,
  output logic                            stillness_seen,
  output logic                            recovered,
  output logic [fwc_pkg::CONF_W-1:0]      confidence,
  output logic                            window_overflow
);

  fwc_pkg::fwc_cmd_t cmd;
  fwc_pkg::fwc_status_t status;

  fwc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_sample (last_sample),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd)
  );

  fwc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .accel_magnitude (accel_magnitude),
    .gyro_magnitude  (gyro_magnitude),
    .is_fall         (is_fall),
    .fall_state      (fall_state),
    .free_fall_seen  (free_fall_seen),
    .impact_seen     (impact_seen),
    .rotation_seen   (rotation_seen),
    .stillness_seen  (stillness_seen),
    .recovered       (recovered),
    .confidence      (confidence),
    .window_overflow (window_overflow)
  );

`include "fall_window_classifier_assert.svh"

  `FWC_ASSERT_NEXT(a_window_end_holds_input, in_valid && in_ready && last_sample, !in_ready, "input not held off after window end")
  `FWC_ASSERT_SAME(a_fall_flag_matches_conf, out_valid, is_fall == (confidence >= fwc_pkg::FALL_CONF_MIN), "is_fall disagrees with confidence")
  `FWC_ASSERT_SAME(a_resolved_fields, out_valid && (fall_state == fwc_pkg::STATE_RESOLVED), recovered && !stillness_seen && (confidence == fwc_pkg::CONF_NONE), "resolved result fields inconsistent")

endmodule
